### sv/slri_pkg.sv
// Shared types, constants and helper functions for the scaled logistic regression block.
package slri_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxFeaturesDefault    = 64;
  localparam int unsigned SigmoidEntriesDefault = 1024;

  // Configuration port
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [CfgIdxWidth-1:0] CfgNumFeatures   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgBiasWeight    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgClassThresh   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgLikelyThresh  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgUnsureThresh  = 3'd4;

  localparam logic [6:0]         NumFeaturesReset  = 7'd32;
  localparam logic signed [31:0] BiasWeightReset   = 32'sd0;
  localparam logic [15:0]        ClassThreshReset  = 16'd32768;
  localparam logic [15:0]        LikelyThreshReset = 16'd45875;
  localparam logic [15:0]        UnsureThreshReset = 16'd29491;

  // Request and verdict codes
  localparam logic       ReqLoad = 1'b0;
  localparam logic       ReqFeat = 1'b1;
  localparam logic [1:0] VerdictNeg    = 2'd0;
  localparam logic [1:0] VerdictUnsure = 2'd1;
  localparam logic [1:0] VerdictPos    = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [5:0]         coef_index;
    logic signed [31:0] coef_mean;
    logic [31:0]        coef_inv_std;
    logic signed [31:0] coef_weight;
    logic signed [31:0] feature_value;
    logic               last_feature;
  } slri_in_t;

  typedef struct packed {
    logic [15:0] probability;
    logic        predicted_class;
    logic [1:0]  verdict;
    logic        count_error;
  } slri_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic take;
    logic mul1;
    logic mul2;
    logic acc;
    logic bias;
    logic lut;
    logic emit;
  } slri_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic out_free;
  } slri_sts_t;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] sum;
    sum = a + b;
    if ((a[63] == b[63]) && (sum[63] != a[63])) begin
      sum = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return sum;
  endfunction

  // Shift-subtract division, used only while building constant tables
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // (a*b)>>32 for unsigned Q32 operands
  function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
    logic [63:0] ah;
    logic [63:0] al;
    logic [63:0] bh;
    logic [63:0] bl;
    ah = a >> 32;
    al = {32'd0, a[31:0]};
    bh = b >> 32;
    bl = {32'd0, b[31:0]};
    return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
  endfunction

  // Sigmoid at the midpoint of interval i out of n over [-8, 8), Q0.16
  function automatic logic [15:0] sig_entry(int unsigned i, int unsigned n);
    logic [63:0] n64;
    logic [63:0] odd;
    logic        pos;
    logic [63:0] mag;
    logic [63:0] x;
    logic [63:0] f;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] p;
    n64  = 64'(n);
    odd  = 64'(2 * i + 1);
    pos  = (odd >= n64);
    mag  = pos ? odd - n64 : n64 - odd;
    x    = udiv64(mag << 35, n64);
    f    = x >> 3;
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 16; k++) begin
      term = udiv64((term * f) >> 32, 64'(k));
      sum  = sum + term;
    end
    e = mul_q32(sum, sum);
    e = mul_q32(e, e);
    e = mul_q32(e, e);
    d = e + (64'd1 << 32);
    if (pos) begin
      p = udiv64((e << 16) + (d >> 1), d);
    end else begin
      p = udiv64((64'd1 << 48) + (d >> 1), d);
    end
    if (p > 64'd65535) begin
      p = 64'd65535;
    end
    return p[15:0];
  endfunction

endpackage

### sv/slri_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module slri_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/slri_sig_rom.sv
// Sigmoid lookup ROM, contents built at elaboration, registered read.
module slri_sig_rom #(
  parameter int unsigned Entries = slri_pkg::SigmoidEntriesDefault,
  localparam int unsigned IdxW = $clog2(Entries)
) (
  input  logic            clk_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] addr_i,
  output logic [15:0]     rdata_o
);

  logic [15:0] rom [Entries];
  logic [15:0] rdata_q;

  for (genvar g = 0; g < Entries; g++) begin : g_rom
    localparam logic [15:0] Val = slri_pkg::sig_entry(g, Entries);
    assign rom[g] = Val;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= rom[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/slri_ctrl.sv
// Controller state machine: sequences loads, feature steps and result output.
module slri_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                req_type_i,
  input  slri_pkg::slri_sts_t sts_i,
  output logic                in_ready_o,
  output slri_pkg::slri_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StFetch = 7'b0000010,
    StMul   = 7'b0000100,
    StAcc   = 7'b0001000,
    StBias  = 7'b0010000,
    StLut   = 7'b0100000,
    StOut   = 7'b1000000
  } slri_state_e;

  slri_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == slri_pkg::ReqFeat) begin
            cmd_o.take = 1'b1;
            state_d    = StFetch;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      StFetch: begin
        cmd_o.mul1 = 1'b1;
        state_d    = StMul;
      end
      StMul: begin
        cmd_o.mul2 = 1'b1;
        state_d    = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.last ? StBias : StIdle;
      end
      StBias: begin
        cmd_o.bias = 1'b1;
        state_d    = StLut;
      end
      StLut: begin
        cmd_o.lut = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/slri_dp.sv
// Datapath: coefficient RAM, scaling multipliers, accumulator, sigmoid lookup, output register.
module slri_dp #(
  parameter int unsigned MaxFeatures    = slri_pkg::MaxFeaturesDefault,
  parameter int unsigned SigmoidEntries = slri_pkg::SigmoidEntriesDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  slri_pkg::slri_cmd_t                   cmd_i,
  output slri_pkg::slri_sts_t                   sts_o,
  input  slri_pkg::slri_in_t                    in_data_i,
  input  logic                                  cfg_we_i,
  input  logic [slri_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [slri_pkg::CfgDataWidth-1:0]     cfg_wdata_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output slri_pkg::slri_out_t                   out_data_o
);

  localparam int unsigned AddrW = (MaxFeatures > 1) ? $clog2(MaxFeatures) : 1;
  localparam int unsigned IdxW  = $clog2(SigmoidEntries);
  localparam int unsigned ProdW = 21 + IdxW;

  // Configuration registers
  logic [6:0]         num_features_q;
  logic signed [31:0] bias_weight_q;
  logic [15:0]        class_thresh_q;
  logic [15:0]        likely_thresh_q;
  logic [15:0]        unsure_thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_features_q  <= slri_pkg::NumFeaturesReset;
      bias_weight_q   <= slri_pkg::BiasWeightReset;
      class_thresh_q  <= slri_pkg::ClassThreshReset;
      likely_thresh_q <= slri_pkg::LikelyThreshReset;
      unsure_thresh_q <= slri_pkg::UnsureThreshReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slri_pkg::CfgNumFeatures:  num_features_q  <= cfg_wdata_i[6:0];
        slri_pkg::CfgBiasWeight:   bias_weight_q   <= $signed(cfg_wdata_i);
        slri_pkg::CfgClassThresh:  class_thresh_q  <= cfg_wdata_i[15:0];
        slri_pkg::CfgLikelyThresh: likely_thresh_q <= cfg_wdata_i[15:0];
        slri_pkg::CfgUnsureThresh: unsure_thresh_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Sample state
  logic [6:0]         pos_q;
  logic [6:0]         pos_snap_q;
  logic               active_q;
  logic               last_q;
  logic signed [31:0] value_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] t_val;

  // Coefficient RAM: {mean, inv_std, weight} per row
  logic        row_ok;
  logic [95:0] coef_rdata;

  assign row_ok = 9'(in_data_i.coef_index) < 9'(MaxFeatures);

  slri_ram #(
    .Width (96),
    .Depth (MaxFeatures)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && row_ok),
    .waddr_i (AddrW'(in_data_i.coef_index)),
    .wdata_i ({in_data_i.coef_mean, in_data_i.coef_inv_std, in_data_i.coef_weight}),
    .re_i    (cmd_i.take),
    .raddr_i (AddrW'(pos_q)),
    .rdata_o (coef_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      acc_q    <= '0;
      active_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        active_q <= (pos_q < num_features_q) && (9'(pos_q) < 9'(MaxFeatures));
        last_q   <= in_data_i.last_feature;
        // saturate at the top of the range
        if (pos_q != 7'h7F) begin
          pos_q <= pos_q + 7'd1;
        end
      end
      if (cmd_i.acc && active_q) begin
        acc_q <= slri_pkg::sat_add64(acc_q, t_val);
      end
      if (cmd_i.emit) begin
        acc_q <= '0;
        pos_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      value_q    <= in_data_i.feature_value;
      pos_snap_q <= pos_q;
    end
  end

  // Stage 1: (value - mean) * inv_std
  logic signed [31:0] mean_w;
  logic [31:0]        inv_std_w;
  logic signed [31:0] weight_w;
  logic signed [32:0] diff;
  logic signed [65:0] p1_d;
  logic signed [65:0] p1_q;

  assign mean_w    = $signed(coef_rdata[95:64]);
  assign inv_std_w = coef_rdata[63:32];
  assign weight_w  = $signed(coef_rdata[31:0]);
  assign diff      = {value_q[31], value_q} - {mean_w[31], mean_w};
  assign p1_d      = diff * $signed({1'b0, inv_std_w});

  // Stage 2: truncate toward zero, saturate, multiply by weight
  logic signed [65:0] p1_adj;
  logic signed [65:0] s_wide;
  logic signed [31:0] s_sat;
  logic signed [63:0] p2_d;
  logic signed [63:0] p2_q;

  always_comb begin
    p1_adj = p1_q[65] ? p1_q + 66'sd65535 : p1_q;
    s_wide = p1_adj >>> 16;
    if (s_wide > 66'sh7FFFFFFF) begin
      s_sat = 32'sh7FFFFFFF;
    end else if (s_wide < -66'sh80000000) begin
      s_sat = 32'sh80000000;
    end else begin
      s_sat = s_wide[31:0];
    end
  end

  assign p2_d = s_sat * weight_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p1_q <= p1_d;
    end
    if (cmd_i.mul2) begin
      p2_q <= p2_d;
    end
  end

  // Stage 3: truncate toward zero before accumulation
  logic signed [63:0] p2_adj;

  assign p2_adj = p2_q[63] ? p2_q + 64'sd65535 : p2_q;
  assign t_val  = p2_adj >>> 16;

  // Bias add and clamp to [-8, 8), offset to an unsigned 20-bit position
  logic signed [63:0] z_val;
  logic [19:0]        u_d;
  logic [19:0]        u_q;

  always_comb begin
    z_val = slri_pkg::sat_add64(acc_q, {{32{bias_weight_q[31]}}, bias_weight_q});
    if (z_val < -64'sd524288) begin
      u_d = '0;
    end else if (z_val > 64'sd524287) begin
      u_d = '1;
    end else begin
      u_d = {~z_val[19], z_val[18:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bias) begin
      u_q <= u_d;
    end
  end

  // Table index: floor(u * entries / 2^20)
  logic [ProdW-1:0] idx_prod;
  logic [IdxW-1:0]  lut_idx;
  logic [15:0]      prob;

  assign idx_prod = ProdW'(u_q) * ProdW'(SigmoidEntries);
  assign lut_idx  = idx_prod[19+IdxW:20];

  slri_sig_rom #(
    .Entries (SigmoidEntries)
  ) u_sig_rom (
    .clk_i   (clk_i),
    .re_i    (cmd_i.lut),
    .addr_i  (lut_idx),
    .rdata_o (prob)
  );

  // Output register
  logic               out_valid_q;
  slri_pkg::slri_out_t out_q;
  logic [7:0]         cnt;

  assign cnt = {1'b0, pos_snap_q} + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.probability     <= prob;
      out_q.predicted_class <= (prob >= class_thresh_q);
      if (prob >= likely_thresh_q) begin
        out_q.verdict <= slri_pkg::VerdictPos;
      end else if (prob >= unsure_thresh_q) begin
        out_q.verdict <= slri_pkg::VerdictUnsure;
      end else begin
        out_q.verdict <= slri_pkg::VerdictNeg;
      end
      out_q.count_error <= (cnt != {1'b0, num_features_q});
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

### sv/scaled_logistic_regression_infer.sv
// Standardized logistic regression inference: top level.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries two kinds of word.
// A coefficient load (req_type 0) writes the mean, reciprocal standard deviation
// and weight of one feature row and produces no result.
// A feature word (req_type 1) scales one Q16.16 value and adds it to the score.
// Each feature passes the coefficient RAM read, (value - mean) * inv_std,
// times weight, then the 64-bit saturating accumulate. The next word is taken
// once that chain is done, so features are accepted one at a time.
// On a word marked last_feature, the bias add and clamp of z, the sigmoid ROM
// read and the output write follow; the result appears on out_valid_o and
// the sample state clears. Coefficient rows hold nothing until loaded.
// The result sits in an output register: while the receiver stalls, further
// loads and features of the next sample are still accepted; only a second
// finished sample waits until the first result is taken.
// Reset clears the score, the feature count and the output valid, and restores
// the configuration defaults. The user must write configuration (cfg_we_i /
// cfg_idx_i / cfg_wdata_i) only while idle; the block leaves this unchecked.
module scaled_logistic_regression_infer #(
  parameter int unsigned MaxFeatures    = slri_pkg::MaxFeaturesDefault,
  parameter int unsigned SigmoidEntries = slri_pkg::SigmoidEntriesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  slri_pkg::slri_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output slri_pkg::slri_out_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [slri_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [slri_pkg::CfgDataWidth-1:0] cfg_wdata_i
);

  slri_pkg::slri_cmd_t cmd;
  slri_pkg::slri_sts_t sts;

  slri_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  slri_dp #(
    .MaxFeatures    (MaxFeatures),
    .SigmoidEntries (SigmoidEntries)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
